### sv/tpa_pkg.sv
// Shared types and constants for the throttle / pedal-assist pulse generator.
// Used by tpa_ctrl, tpa_datapath and throttle_pedal_assist_ppm_top; no dependencies.
package tpa_pkg;

    // Throttle converter resolution
    localparam int SAMPLE_BITS = 12;
    localparam int CEIL_W      = SAMPLE_BITS + 1;

    // Map operands must hold the ceiling and the assist span (4000)
    localparam int MAP_BITS  = (CEIL_W > 12) ? CEIL_W : 12;
    localparam int PULSE_W   = 16;
    localparam int DELTA_W   = PULSE_W + 1;
    localparam int PROD_W    = MAP_BITS + PULSE_W;
    localparam int DIV_STEPS = (PROD_W + 1) / 2;     // two quotient bits per step
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int REM_W     = MAP_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Stream widths
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = ((SAMPLE_BITS + 16 + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W;
    localparam int MODE_W    = 2;
    localparam int M_TDATA_W = PULSE_W;
    localparam int M_TUSER_W = MODE_W + 2;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ASSIST_LEVEL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_ENABLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LOW     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_HIGH    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_MID  = 3'd7;

    // Event codes
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd3;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ASSIST   = 2'd2;

    // Calibration phases
    localparam logic [1:0] CAL_DONE  = 2'd0;
    localparam logic [1:0] CAL_WAIT  = 2'd1;
    localparam logic [1:0] CAL_CEIL  = 2'd2;
    localparam logic [1:0] CAL_FLOOR = 2'd3;

    // Fixed values
    localparam logic [PULSE_W-1:0]  OFF_PULSE        = 16'd500;
    localparam logic [MAP_BITS-1:0] ASSIST_STEP      = MAP_BITS'(1000);
    localparam logic [MAP_BITS-1:0] ASSIST_SPAN      = MAP_BITS'(4000);
    localparam logic [3:0]          ASSIST_MAX_LEVEL = 4'd4;
    localparam logic [CEIL_W-1:0]   CEIL_RESET       = {1'b1, {SAMPLE_BITS{1'b0}}};

    // Register reset values
    localparam logic [3:0]  RST_ASSIST_LEVEL = 4'd1;
    localparam logic [15:0] RST_PERIOD_LIMIT = 16'd20000;
    localparam logic [15:0] RST_HYSTERESIS   = 16'd100;
    localparam logic [11:0] RST_IDLE_LIMIT   = 12'd100;
    localparam logic [15:0] RST_PULSE_LOW    = 16'd500;
    localparam logic [15:0] RST_PULSE_HIGH   = 16'd2500;
    localparam logic [11:0] RST_MID          = 12'd2048;

    // Controller -> datapath
    typedef struct packed {
        logic take_item;   // input transaction this cycle
        logic mul;         // form the map product
        logic div_step;    // two restoring divide steps
        logic load_out;    // move result into the output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
    } stat_t;

endpackage

### sv/tpa_ctrl.sv
// Sequencer for the pulse generator: input handshake, multiply/divide steps, result hand-off.
// Depends on tpa_pkg.
module tpa_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tpa_pkg::S_TUSER_W-1:0]  s_tuser,
    input  tpa_pkg::stat_t                 stat,
    output tpa_pkg::cmd_t                  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [tpa_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no transaction is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.take_item = 1'b1;
                    if (s_tuser == tpa_pkg::OP_REFRESH) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = tpa_pkg::CNT_W'(tpa_pkg::DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN: begin
                // wait here only while a previous result is still unread
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/tpa_datapath.sv
// Datapath: config registers, calibration and pedal state, map setup, multiplier,
// radix-4 restoring divider and output register. Depends on tpa_pkg.
module tpa_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tpa_pkg::cmd_t                    cmd,
    output tpa_pkg::stat_t                   stat,
    input  logic [tpa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [tpa_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             cfg_write,
    input  logic [tpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tpa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tpa_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int SB = tpa_pkg::SAMPLE_BITS;
    localparam int MB = tpa_pkg::MAP_BITS;
    localparam int PW = tpa_pkg::PULSE_W;
    localparam int DW = tpa_pkg::DIV_W;
    localparam int RW = tpa_pkg::REM_W;

    // configuration
    logic [3:0]    assist_level_reg;
    logic          output_enable_reg;
    logic [15:0]   period_limit_reg;
    logic [15:0]   hysteresis_reg;
    logic [11:0]   idle_limit_reg;
    logic [PW-1:0] pulse_low_reg;
    logic [PW-1:0] pulse_high_reg;
    logic [11:0]   mid_reg;

    // event state
    logic [1:0]                  calib_phase_reg;
    logic [SB-1:0]               floor_reg;
    logic [tpa_pkg::CEIL_W-1:0]  ceil_reg;
    logic [SB-1:0]               level_reg;
    logic                        pedal_active_reg;
    logic                        capture_seen_reg;

    // refresh computation
    logic [MB-1:0]                 diff_reg;
    logic [MB-1:0]                 span_reg;
    logic [PW-1:0]                 dmag_reg;
    logic                          neg_reg;
    logic                          early_reg;
    logic [PW-1:0]                 early_pulse_reg;
    logic [tpa_pkg::MODE_W-1:0]    mode_reg;
    logic                          pflag_reg;
    logic                          calib_flag_reg;
    logic [DW-1:0]                 quo_reg;
    logic [RW-1:0]                 rem_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [PW-1:0]                 m_pulse_reg;
    logic [tpa_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic [tpa_pkg::OP_W-1:0] op;
    logic [SB-1:0]            sample;
    logic [15:0]              period;
    logic                     high;
    logic [16:0]              pedal_limit;
    logic                     assist_sel;
    logic [MB-1:0]            assist_v;
    logic [MB-1:0]            map_v, map_lo, map_hi;
    logic [tpa_pkg::DELTA_W-1:0] delta;
    logic [tpa_pkg::DELTA_W-1:0] delta_neg;
    logic [tpa_pkg::PROD_W-1:0]  product;
    logic [DW-1:0]            quo_step;
    logic [RW-1:0]            rem_step;
    logic [RW-1:0]            trial;
    logic [PW-1:0]            quo16;
    logic [PW-1:0]            pulse_calc;

    assign op     = s_tuser;
    assign sample = s_tdata[SB-1:0];
    assign period = s_tdata[SB+15:SB];
    assign high   = MB'(sample) > MB'(mid_reg);

    assign pedal_limit = {1'b0, period_limit_reg}
                       + (pedal_active_reg ? {1'b0, hysteresis_reg} : 17'd0);

    // map setup: choose assist point or throttle level
    assign assist_v   = tpa_pkg::ASSIST_STEP * MB'(assist_level_reg);
    assign assist_sel = (MB'(level_reg) < MB'(idle_limit_reg)) && pedal_active_reg
                     && (assist_level_reg != 4'd0)
                     && (assist_level_reg <= tpa_pkg::ASSIST_MAX_LEVEL);
    assign map_v  = assist_sel ? assist_v : MB'(level_reg);
    assign map_lo = assist_sel ? '0 : MB'(floor_reg);
    assign map_hi = assist_sel ? tpa_pkg::ASSIST_SPAN : MB'(ceil_reg);

    assign delta     = {1'b0, pulse_high_reg} - {1'b0, pulse_low_reg};
    assign delta_neg = ~delta + 1'b1;
    assign product   = tpa_pkg::PROD_W'(diff_reg) * tpa_pkg::PROD_W'(dmag_reg);

    // two restoring steps; quotient bits shift in as dividend bits shift out
    always_comb begin
        quo_step = quo_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++) begin
            trial    = {rem_step[RW-2:0], quo_step[DW-1]};
            quo_step = {quo_step[DW-2:0], 1'b0};
            if (trial >= {1'b0, span_reg}) begin
                trial       = trial - {1'b0, span_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = trial;
        end
    end

    // quotient magnitude is below |delta|, so 16 bits hold it
    assign quo16      = quo_reg[PW-1:0];
    assign pulse_calc = pulse_low_reg + (neg_reg ? (~quo16 + 1'b1) : quo16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assist_level_reg  <= tpa_pkg::RST_ASSIST_LEVEL;
            output_enable_reg <= 1'b1;
            period_limit_reg  <= tpa_pkg::RST_PERIOD_LIMIT;
            hysteresis_reg    <= tpa_pkg::RST_HYSTERESIS;
            idle_limit_reg    <= tpa_pkg::RST_IDLE_LIMIT;
            pulse_low_reg     <= tpa_pkg::RST_PULSE_LOW;
            pulse_high_reg    <= tpa_pkg::RST_PULSE_HIGH;
            mid_reg           <= tpa_pkg::RST_MID;
        end else if (cfg_write) begin
            unique case (cfg_index)
                tpa_pkg::REG_ASSIST_LEVEL:  assist_level_reg  <= cfg_data[3:0];
                tpa_pkg::REG_OUTPUT_ENABLE: output_enable_reg <= cfg_data[0];
                tpa_pkg::REG_PERIOD_LIMIT:  period_limit_reg  <= cfg_data;
                tpa_pkg::REG_HYSTERESIS:    hysteresis_reg    <= cfg_data;
                tpa_pkg::REG_IDLE_LIMIT:    idle_limit_reg    <= cfg_data[11:0];
                tpa_pkg::REG_PULSE_LOW:     pulse_low_reg     <= cfg_data;
                tpa_pkg::REG_PULSE_HIGH:    pulse_high_reg    <= cfg_data;
                tpa_pkg::REG_THROTTLE_MID:  mid_reg           <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_phase_reg  <= tpa_pkg::CAL_WAIT;
            floor_reg        <= '0;
            ceil_reg         <= tpa_pkg::CEIL_RESET;
            level_reg        <= '0;
            pedal_active_reg <= 1'b0;
            capture_seen_reg <= 1'b1;
        end else if (cmd.take_item) begin
            case (op)
                tpa_pkg::OP_SAMPLE: begin
                    case (calib_phase_reg)
                        tpa_pkg::CAL_DONE: level_reg <= sample;
                        tpa_pkg::CAL_WAIT: begin
                            if (high) begin
                                calib_phase_reg <= tpa_pkg::CAL_CEIL;
                                ceil_reg        <= tpa_pkg::CEIL_W'(sample);
                            end else begin
                                calib_phase_reg <= tpa_pkg::CAL_DONE;
                            end
                        end
                        tpa_pkg::CAL_CEIL: begin
                            if (!high) begin
                                calib_phase_reg <= tpa_pkg::CAL_FLOOR;
                                floor_reg       <= sample;
                            end else if (tpa_pkg::CEIL_W'(sample) > ceil_reg) begin
                                ceil_reg <= tpa_pkg::CEIL_W'(sample);
                            end
                        end
                        tpa_pkg::CAL_FLOOR: begin
                            if (high) begin
                                calib_phase_reg <= tpa_pkg::CAL_DONE;
                            end else if (sample < floor_reg) begin
                                floor_reg <= sample;
                            end
                        end
                    endcase
                end
                tpa_pkg::OP_CAPTURE: begin
                    if ({1'b0, period} < pedal_limit) begin
                        if (capture_seen_reg) begin
                            pedal_active_reg <= 1'b1;
                        end
                    end else begin
                        pedal_active_reg <= 1'b0;
                    end
                    capture_seen_reg <= 1'b1;
                end
                tpa_pkg::OP_TIMEOUT: begin
                    if (!capture_seen_reg) begin
                        pedal_active_reg <= 1'b0;
                    end else begin
                        capture_seen_reg <= 1'b0;
                    end
                end
                tpa_pkg::OP_REFRESH: ;
            endcase
        end
    end

    // refresh setup, product and divider; payload only, no reset
    always_ff @(posedge aclk) begin
        if (cmd.take_item && (op == tpa_pkg::OP_REFRESH)) begin
            diff_reg       <= map_v - map_lo;
            span_reg       <= map_hi - map_lo;
            neg_reg        <= delta[tpa_pkg::DELTA_W-1];
            dmag_reg       <= delta[tpa_pkg::DELTA_W-1] ? delta_neg[PW-1:0] : delta[PW-1:0];
            pflag_reg      <= pedal_active_reg;
            calib_flag_reg <= (calib_phase_reg != tpa_pkg::CAL_DONE);
            if (!output_enable_reg) begin
                early_reg       <= 1'b1;
                early_pulse_reg <= tpa_pkg::OFF_PULSE;
                mode_reg        <= tpa_pkg::MODE_OFF;
            end else begin
                early_reg       <= (map_v <= map_lo) || (map_v >= map_hi);
                early_pulse_reg <= (map_v <= map_lo) ? pulse_low_reg : pulse_high_reg;
                mode_reg        <= assist_sel ? tpa_pkg::MODE_ASSIST : tpa_pkg::MODE_THROTTLE;
            end
        end
        if (cmd.mul) begin
            quo_reg <= DW'(product);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_pulse_reg <= early_reg ? early_pulse_reg : pulse_calc;
            m_tuser_reg <= {calib_flag_reg, pflag_reg, mode_reg};
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_pulse_reg;
    assign m_tuser       = m_tuser_reg;

endmodule

### sv/throttle_pedal_assist_ppm_top.sv
// Top level of the throttle / pedal-assist servo pulse generator.
// Depends on tpa_pkg, tpa_ctrl and tpa_datapath.

// Takes throttle samples, pedal period captures, pedal timeout ticks and refresh
// ticks on one input stream (event code in s_tuser) and answers each refresh with
// one servo pulse width. Sample, capture and timeout events leave the block idle and
// produce nothing. A refresh holds the input through setup, the multiply, 15 steps of
// the shared restoring divider at two quotient bits a step, and the load of the output
// register; that load waits while an earlier result is still unread.
// Configuration writes are taken whenever reset is released and must only be issued
// while the block is idle. No clearing pass after reset.
module throttle_pedal_assist_ppm_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tpa_pkg::S_TDATA_W-1:0]    s_tdata,   // sample, capture_period, zero pad
    input  logic [tpa_pkg::S_TUSER_W-1:0]    s_tuser,   // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tpa_pkg::M_TDATA_W-1:0]    m_tdata,   // pulse_width
    output logic [tpa_pkg::M_TUSER_W-1:0]    m_tuser,   // drive_mode, pedal_flag, calibrating
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tpa_pkg::cmd_t  cmd;
    tpa_pkg::stat_t stat;
    logic           cfg_write;

    assign cfg_ready = aresetn;
    assign cfg_write = cfg_valid && cfg_ready;

    tpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for throttle_pedal_assist_ppm_top: directed and random event streams,
// every refresh result checked against an in-bench predictor. Depends on tpa_pkg.
module tb;
    import tpa_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 24;     // outlasts the time a refresh holds the input
    localparam int PHASE_ITEMS   = 175;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic [MODE_W-1:0]  drive_mode;
        logic               pedal_flag;
        logic               calibrating;
    } servo_cmd_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    servo_cmd_t  expected_cmds[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_hold     = 0;
    bit          steady      = 1'b0;   // no idling on either side

    // Predictor copy of the registers
    logic [3:0]  p_assist;
    logic        p_enable;
    logic [15:0] p_period_limit;
    logic [15:0] p_hyst;
    logic [11:0] p_idle;
    logic [15:0] p_pulse_lo;
    logic [15:0] p_pulse_hi;
    logic [11:0] p_mid;

    // Predictor copy of the state
    logic [1:0]  cal_phase;
    logic [11:0] thr_floor;
    logic [12:0] thr_ceiling;
    logic [11:0] thr_level;
    logic        pedaling;
    logic        capture_seen;

    throttle_pedal_assist_ppm_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // sample, capture_period, zero pad
        .s_tuser   (s_tuser),     // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // pulse_width
        .m_tuser   (m_tuser),     // drive_mode, pedal_flag, calibrating
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Clamped linear map, signed quotient truncated toward zero
    function automatic logic [15:0] servo_map(int unsigned v, int unsigned lo, int unsigned hi);
        longint span;
        longint delta;
        longint q;
        if (v <= lo) return p_pulse_lo;
        if (v >= hi) return p_pulse_hi;
        span  = longint'(hi) - longint'(lo);
        delta = longint'(p_pulse_hi) - longint'(p_pulse_lo);
        q     = (longint'(v - lo) * delta) / span;
        return 16'(longint'(p_pulse_lo) + q);
    endfunction

    function automatic servo_cmd_t predict_refresh();
        servo_cmd_t c;
        if (!p_enable) begin
            c.pulse_width = OFF_PULSE;
            c.drive_mode  = MODE_OFF;
        end else if (thr_level < p_idle && pedaling &&
                     p_assist >= 1 && p_assist <= ASSIST_MAX_LEVEL) begin
            c.pulse_width = servo_map(int'(ASSIST_STEP) * int'(p_assist), 0, int'(ASSIST_SPAN));
            c.drive_mode  = MODE_ASSIST;
        end else begin
            c.pulse_width = servo_map(thr_level, thr_floor, thr_ceiling);
            c.drive_mode  = MODE_THROTTLE;
        end
        c.pedal_flag  = pedaling;
        c.calibrating = (cal_phase != CAL_DONE);
        return c;
    endfunction

    // Calibration: wait -> (ceiling -> floor ->) done; no level stored meanwhile
    function automatic void apply_sample(logic [11:0] s);
        case (cal_phase)
            CAL_DONE: thr_level = s;
            CAL_WAIT: begin
                if (s > p_mid) begin
                    cal_phase   = CAL_CEIL;
                    thr_ceiling = {1'b0, s};
                end else begin
                    cal_phase = CAL_DONE;
                end
            end
            CAL_CEIL: begin
                if (s > p_mid) begin
                    if ({1'b0, s} > thr_ceiling) thr_ceiling = {1'b0, s};
                end else begin
                    cal_phase = CAL_FLOOR;
                    thr_floor = s;
                end
            end
            default: begin
                if (s > p_mid) cal_phase = CAL_DONE;
                else if (s < thr_floor) thr_floor = s;
            end
        endcase
    endfunction

    // Checks results, then tracks config writes and accepted events
    always @(posedge aclk) begin
        servo_cmd_t got;
        servo_cmd_t want;
        logic [16:0] period_bound;
        logic [15:0] period;
        if (!aresetn) begin
            p_assist       = RST_ASSIST_LEVEL;
            p_enable       = 1'b1;
            p_period_limit = RST_PERIOD_LIMIT;
            p_hyst         = RST_HYSTERESIS;
            p_idle         = RST_IDLE_LIMIT;
            p_pulse_lo     = RST_PULSE_LOW;
            p_pulse_hi     = RST_PULSE_HIGH;
            p_mid          = RST_MID;
            cal_phase      = CAL_WAIT;
            thr_floor      = '0;
            thr_ceiling    = CEIL_RESET;
            thr_level      = '0;
            pedaling       = 1'b0;
            capture_seen   = 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3]};
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result pw %0d mode %0d ped %0d cal %0d",
                                 $time, got.pulse_width, got.drive_mode,
                                 got.pedal_flag, got.calibrating);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp pw %0d mode %0d ped %0d cal %0d,",
                                      " got pw %0d mode %0d ped %0d cal %0d"}, $time,
                                     want.pulse_width, want.drive_mode, want.pedal_flag,
                                     want.calibrating, got.pulse_width, got.drive_mode,
                                     got.pedal_flag, got.calibrating);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ASSIST_LEVEL:  p_assist       = cfg_data[3:0];
                    REG_OUTPUT_ENABLE: p_enable       = cfg_data[0];
                    REG_PERIOD_LIMIT:  p_period_limit = cfg_data;
                    REG_HYSTERESIS:    p_hyst         = cfg_data;
                    REG_IDLE_LIMIT:    p_idle         = cfg_data[11:0];
                    REG_PULSE_LOW:     p_pulse_lo     = cfg_data;
                    REG_PULSE_HIGH:    p_pulse_hi     = cfg_data;
                    REG_THROTTLE_MID:  p_mid          = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_SAMPLE: apply_sample(s_tdata[SAMPLE_BITS-1:0]);
                    OP_CAPTURE: begin
                        period       = s_tdata[SAMPLE_BITS+15:SAMPLE_BITS];
                        period_bound = {1'b0, p_period_limit} + (pedaling ? p_hyst : 16'd0);
                        if ({1'b0, period} < period_bound) begin
                            if (capture_seen) pedaling = 1'b1;
                        end else begin
                            pedaling = 1'b0;
                        end
                        capture_seen = 1'b1;
                    end
                    OP_TIMEOUT: begin
                        if (!capture_seen) pedaling = 1'b0;
                        else capture_seen = 1'b0;
                    end
                    default: expected_cmds.push_back(predict_refresh());
                endcase
            end
        end
    end

    // Result side: random stalls, long holds on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Leaves tvalid high on return so back-to-back events need no extra edge
    task automatic send_event(input logic [OP_W-1:0] op, input logic [11:0] smp,
                              input logic [15:0] per);
        if (!steady && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({per, smp});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending, let every pending result drain, then let the block settle.
    // One edge first so a refresh taken at the last edge is already queued.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_calibration();
        int unsigned mid_v;
        int unsigned top;
        int unsigned bottom;
        mid_v  = $urandom_range(1000, 3000);
        top    = $urandom_range(mid_v + 1, 4094);
        bottom = $urandom_range(1, mid_v);
        set_reg(REG_THROTTLE_MID, {4'($urandom), 12'(mid_v)});
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));  // before any sample
        send_event(OP_SAMPLE, 12'(top), 16'($urandom));
        send_event(OP_SAMPLE, 12'(mid_v + 1), 16'($urandom)); // no new peak, stays
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_SAMPLE, 12'(bottom), 16'($urandom));
        send_event(OP_SAMPLE, 12'(mid_v), 16'($urandom));     // no new low, stays
        send_event(OP_SAMPLE, 12'(bottom - 1), 16'($urandom));
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_SAMPLE, 12'(mid_v + 1), 16'($urandom)); // ends, not stored
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_SAMPLE, 12'hfff, 16'hffff);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_SAMPLE, 12'h000, 16'h0000);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
    endtask

    task automatic test_pedal_detect();
        send_event(OP_CAPTURE, 12'($urandom), 16'd0);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_CAPTURE, 12'($urandom), 16'd20099);     // inside hysteresis
        send_event(OP_TIMEOUT, 12'($urandom), 16'($urandom));
        send_event(OP_TIMEOUT, 12'($urandom), 16'($urandom)); // quiet interval, drops
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        // fast capture right after a timeout only rearms
        send_event(OP_CAPTURE, 12'($urandom), 16'd5);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_CAPTURE, 12'($urandom), 16'd19999);
        send_event(OP_CAPTURE, 12'($urandom), 16'hffff);
        send_event(OP_CAPTURE, 12'($urandom), 16'd20000);
        send_event(OP_CAPTURE, 12'($urandom), 16'd0);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
    endtask

    // Pedaling with throttle idle: assist range, output off, inverted pulse range
    task automatic test_output_select();
        wait_quiet();
        set_reg(REG_ASSIST_LEVEL, 16'h0000);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        wait_quiet();
        set_reg(REG_ASSIST_LEVEL, 16'h0004);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        wait_quiet();
        set_reg(REG_ASSIST_LEVEL, 16'hfff5);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        wait_quiet();
        set_reg(REG_ASSIST_LEVEL, 16'h0003);
        set_reg(REG_OUTPUT_ENABLE, 16'hfffe);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        wait_quiet();
        set_reg(REG_OUTPUT_ENABLE, 16'h0001);
        set_reg(REG_PULSE_LOW, 16'hffff);
        set_reg(REG_PULSE_HIGH, 16'h0000);
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        send_event(OP_SAMPLE, 12'($urandom_range(200, 4000)), 16'($urandom));
        send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
        wait_quiet();
        set_reg(REG_PULSE_LOW, RST_PULSE_LOW);
        set_reg(REG_PULSE_HIGH, RST_PULSE_HIGH);
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        wait_quiet();
        rx_hold = 400;
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 0) send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
            else send_event(OP_SAMPLE, 12'($urandom), 16'($urandom));
        end
        wait_quiet();
    endtask

    task automatic test_random_mix();
        logic [15:0] cfg_vals[8];
        int          r;
        int          per;
        logic [11:0] smp;
        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            foreach (cfg_vals[i]) cfg_vals[i] = 16'($urandom);
            cfg_vals[REG_ASSIST_LEVEL]  = {12'($urandom), 4'($urandom_range(1, 4))};
            cfg_vals[REG_OUTPUT_ENABLE] = {15'($urandom), 1'b1};
            cfg_vals[REG_PERIOD_LIMIT]  = 16'($urandom_range(100, 30000));
            cfg_vals[REG_IDLE_LIMIT]    = {4'($urandom), 12'($urandom_range(50, 1000))};
            case (ph)
                1: begin
                    cfg_vals[REG_ASSIST_LEVEL] = 16'h0004;
                    cfg_vals[REG_PERIOD_LIMIT] = 16'hffff;
                    cfg_vals[REG_HYSTERESIS]   = 16'hffff;
                    cfg_vals[REG_IDLE_LIMIT]   = 16'h0fff;
                    cfg_vals[REG_PULSE_LOW]    = 16'h0000;
                    cfg_vals[REG_PULSE_HIGH]   = 16'hffff;
                end
                2: begin
                    cfg_vals[REG_ASSIST_LEVEL] = 16'h000f;
                    cfg_vals[REG_PERIOD_LIMIT] = 16'h0000;
                    cfg_vals[REG_HYSTERESIS]   = 16'h0000;
                    cfg_vals[REG_IDLE_LIMIT]   = 16'h0000;
                    cfg_vals[REG_PULSE_LOW]    = 16'hffff;
                    cfg_vals[REG_PULSE_HIGH]   = 16'h0000;
                end
                4: cfg_vals[REG_OUTPUT_ENABLE] = 16'h0000;
                default: ;
            endcase
            foreach (cfg_vals[i]) set_reg(CFG_INDEX_W'(i), cfg_vals[i]);
            steady = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: smp = 12'($urandom_range(0, 150));
                        4:          smp = ($urandom_range(0, 1) != 0) ? 12'hfff : 12'h000;
                        default:    smp = 12'($urandom);
                    endcase
                    send_event(OP_SAMPLE, smp, 16'($urandom));
                end else if (r < 60) begin
                    if ($urandom_range(0, 1) != 0) begin
                        per = int'(cfg_vals[REG_PERIOD_LIMIT]) + $urandom_range(0, 400) - 200;
                        if (per < 0) per = 0;
                        if (per > 65535) per = 65535;
                    end else begin
                        per = $urandom_range(0, 65535);
                    end
                    send_event(OP_CAPTURE, 12'($urandom), 16'(per));
                end else if (r < 75) begin
                    send_event(OP_TIMEOUT, 12'($urandom), 16'($urandom));
                end else begin
                    send_event(OP_REFRESH, 12'($urandom), 16'($urandom));
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_SAMPLE;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ASSIST_LEVEL;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_calibration();
        test_pedal_detect();
        test_output_select();
        test_backpressure();
        test_random_mix();

        wait_quiet();
        mismatches += expected_cmds.size();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
